// ----- src/sws_pkg.sv -----
// shared types and constants for the stopwatch with run statistics
`timescale 1ns / 1ps

package sws_pkg;

  // default widths of the stopwatch count and of the run counter
  localparam int COUNT_BITS_DEF = 32;
  localparam int RUNS_BITS_DEF  = 16;

  // fixed widths of the port fields
  localparam int OP_W      = 3;
  localparam int FIELD_W   = 32;
  localparam int RUN_CNT_W = 16;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // event codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_PAUSE = 3'd2,
    OP_STOP  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // what the statistics side does with a queued event
  typedef enum logic [1:0] {
    STAT_NONE,
    STAT_RECORD,
    STAT_CLEAR
  } stat_kind_t;

  // control part of one queued event
  typedef struct packed {
    stat_kind_t kind;
    logic       running;
    logic       paused;
  } sws_ctl_t;

  localparam int CTL_W = $bits(sws_ctl_t);

  // statistics sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// ----- src/stopwatch_with_run_statistics.sv -----
// Stopwatch with run statistics: top level.
// Input channel (in_valid / in_stall) carries one event per transaction:
//   operation 0 tick, 1 start, 2 pause toggle, 3 stop, 4 clear statistics,
//   with initial_count used by a start from the stopped state.
// Output channel (out_valid / out_stall) returns exactly one result per event:
//   elapsed count, running and paused flags, min, max, average and run count.
// The front end updates the stopwatch in the cycle of the transaction and
// places the event in a two-entry queue; the statistics side drains it.
// Each accepted event is popped by the statistics sequencer and passes through
// BK_OUT into the output register; a stop first runs the serial average
// divide in BK_DIV, one quotient bit per cycle, over COUNT_BITS + RUNS_BITS
// bits (at most 64). The sequencer takes the next event from the queue only
// once the previous result has been loaded into the output register.
// A result waits in the output register while out_stall is high; the queue
// keeps taking events until it fills, then in_stall rises.
// Reset (rst, synchronous) stops the stopwatch and clears all statistics.
`timescale 1ns / 1ps

module stopwatch_with_run_statistics #(
  parameter int COUNT_BITS = sws_pkg::COUNT_BITS_DEF,
  parameter int RUNS_BITS  = sws_pkg::RUNS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sws_pkg::OP_W-1:0]       operation,
  input  logic [sws_pkg::FIELD_W-1:0]    initial_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sws_pkg::FIELD_W-1:0]    elapsed,
  output logic                           running,
  output logic                           paused,
  output logic [sws_pkg::FIELD_W-1:0]    min_time,
  output logic [sws_pkg::FIELD_W-1:0]    max_time,
  output logic [sws_pkg::FIELD_W-1:0]    average_time,
  output logic [sws_pkg::RUN_CNT_W-1:0]  run_count
);
  import sws_pkg::*;

  localparam int QW = CTL_W + COUNT_BITS;

  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  sws_ctl_t              push_ctl;
  logic [COUNT_BITS-1:0] push_count;
  logic [QW-1:0]         q_out;
  sws_ctl_t              head_ctl;
  logic [COUNT_BITS-1:0] head_count;

  assign head_ctl   = sws_ctl_t'(q_out[QW-1:COUNT_BITS]);
  assign head_count = q_out[COUNT_BITS-1:0];

  // event intake and stopwatch
  sws_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .initial_count(initial_count),
    .full         (full),
    .push         (push),
    .push_ctl     (push_ctl),
    .push_count   (push_count)
  );

  // decoupling queue
  sws_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({push_ctl, push_count}),
    .full (full),
    .pop  (pop),
    .dout (q_out),
    .empty(empty)
  );

  // statistics and result
  sws_back #(
    .COUNT_BITS(COUNT_BITS),
    .RUNS_BITS (RUNS_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .pop         (pop),
    .head_ctl    (head_ctl),
    .head_count  (head_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .elapsed     (elapsed),
    .running     (running),
    .paused      (paused),
    .min_time    (min_time),
    .max_time    (max_time),
    .average_time(average_time),
    .run_count   (run_count)
  );

endmodule

// ----- src/sws_front.sv -----
// front end: takes events, runs the stopwatch, queues work for the statistics side
`timescale 1ns / 1ps

module sws_front #(
  parameter int COUNT_BITS = sws_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sws_pkg::OP_W-1:0]     operation,
  input  logic [sws_pkg::FIELD_W-1:0]  initial_count,
  input  logic                         full,
  output logic                         push,
  output sws_pkg::sws_ctl_t            push_ctl,
  output logic [COUNT_BITS-1:0]        push_count
);
  import sws_pkg::*;

  logic [COUNT_BITS-1:0] elapsed_count;
  logic [COUNT_BITS-1:0] elapsed_count_next;
  logic                  started;
  logic                  started_next;
  logic                  paused_flag;
  logic                  paused_flag_next;
  logic [COUNT_BITS-1:0] init_val;
  logic                  is_stop;
  stat_kind_t            kind;

  // a transaction is taken whenever the queue has room
  assign in_stall = full;
  assign push     = in_valid && !full;
  assign init_val = COUNT_BITS'(initial_count);

  // event decode and stopwatch update
  always_comb begin
    elapsed_count_next = elapsed_count;
    started_next       = started;
    paused_flag_next   = paused_flag;
    is_stop            = 1'b0;
    kind               = STAT_NONE;
    case (operation)
      OP_TICK: begin
        if (started && !paused_flag && elapsed_count != '1) begin
          elapsed_count_next = elapsed_count + 1'b1;
        end
      end
      OP_START: begin
        if (!started || paused_flag) begin
          if (!paused_flag && init_val != '0) begin
            elapsed_count_next = init_val;
          end
          paused_flag_next = 1'b0;
          started_next     = 1'b1;
        end
      end
      OP_PAUSE: begin
        if (paused_flag) begin
          paused_flag_next = 1'b0;
        end else if (started) begin
          paused_flag_next = 1'b1;
        end
      end
      OP_STOP: begin
        if (started) begin
          elapsed_count_next = '0;
          started_next       = 1'b0;
          paused_flag_next   = 1'b0;
          is_stop            = 1'b1;
          kind               = STAT_RECORD;
        end
      end
      OP_CLEAR: begin
        kind = STAT_CLEAR;
      end
      default: begin
        kind = STAT_NONE;
      end
    endcase
  end

  // queued work: shown count, flags and statistics action
  assign push_ctl.kind    = kind;
  assign push_ctl.running = started_next;
  assign push_ctl.paused  = paused_flag_next;
  assign push_count       = is_stop ? elapsed_count : elapsed_count_next;

  // stopwatch state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count <= '0;
      started       <= 1'b0;
      paused_flag   <= 1'b0;
    end else if (push) begin
      elapsed_count <= elapsed_count_next;
      started       <= started_next;
      paused_flag   <= paused_flag_next;
    end
  end

endmodule

// ----- src/sws_queue.sv -----
// small register queue between the front and the statistics side
`timescale 1ns / 1ps

module sws_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sws_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import sws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/sws_back.sv -----
// back end: statistics update, serial average divide and result register
`timescale 1ns / 1ps

module sws_back #(
  parameter int COUNT_BITS = sws_pkg::COUNT_BITS_DEF,
  parameter int RUNS_BITS  = sws_pkg::RUNS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  output logic                           pop,
  input  sws_pkg::sws_ctl_t              head_ctl,
  input  logic [COUNT_BITS-1:0]          head_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sws_pkg::FIELD_W-1:0]    elapsed,
  output logic                           running,
  output logic                           paused,
  output logic [sws_pkg::FIELD_W-1:0]    min_time,
  output logic [sws_pkg::FIELD_W-1:0]    max_time,
  output logic [sws_pkg::FIELD_W-1:0]    average_time,
  output logic [sws_pkg::RUN_CNT_W-1:0]  run_count
);
  import sws_pkg::*;

  localparam int SUM_BITS = (COUNT_BITS + RUNS_BITS > 64) ? 64 : COUNT_BITS + RUNS_BITS;
  localparam int DCNT_W   = $clog2(SUM_BITS);
  localparam logic [SUM_BITS-1:0] MEAN_CAP = SUM_BITS'({COUNT_BITS{1'b1}});

  back_state_t state;
  back_state_t state_next;

  sws_ctl_t              hold_ctl;
  logic [COUNT_BITS-1:0] hold_count;

  logic [COUNT_BITS-1:0] min_run;
  logic [COUNT_BITS-1:0] max_run;
  logic [SUM_BITS-1:0]   run_sum;
  logic [RUNS_BITS-1:0]  runs;
  logic [COUNT_BITS-1:0] mean_run;

  logic [RUNS_BITS-1:0]  rem;
  logic [SUM_BITS-1:0]   dq;
  logic [DCNT_W-1:0]     div_cnt;

  logic                  div_step;
  logic                  load_out;
  logic                  out_free;

  logic                  first_run;
  logic [COUNT_BITS-1:0] min_run_next;
  logic [COUNT_BITS-1:0] max_run_next;
  logic [RUNS_BITS-1:0]  runs_next;
  logic [SUM_BITS:0]     sum_ext;
  logic [SUM_BITS-1:0]   run_sum_next;

  logic [RUNS_BITS:0]    trial;
  logic [RUNS_BITS:0]    trial_diff;
  logic                  fits;
  logic [COUNT_BITS-1:0] mean_new;
  logic [COUNT_BITS-1:0] mean_show;

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          state_next = (head_ctl.kind == STAT_RECORD) ? BK_DIV : BK_OUT;
        end
      end
      BK_DIV: begin
        if (div_cnt == DCNT_W'(SUM_BITS - 1)) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop      = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: pop      = !empty;
      BK_DIV:  div_step = 1'b1;
      BK_OUT:  load_out = out_free;
      default: pop      = 1'b0;
    endcase
  end

  // statistics update for a recorded run
  always_comb begin
    first_run    = (runs == '0);
    min_run_next = (first_run || head_count < min_run) ? head_count : min_run;
    max_run_next = (first_run || head_count > max_run) ? head_count : max_run;
    runs_next    = (runs == '1) ? runs : runs + 1'b1;
    sum_ext      = {1'b0, run_sum} + (SUM_BITS + 1)'(head_count);
    run_sum_next = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
  end

  // one restoring divide step: run_sum / runs
  always_comb begin
    trial      = {rem, dq[SUM_BITS-1]};
    trial_diff = trial - {1'b0, runs};
    fits       = (trial >= {1'b0, runs});
  end

  // quotient clamped to the count range
  assign mean_new  = (dq > MEAN_CAP) ? '1 : dq[COUNT_BITS-1:0];
  assign mean_show = (hold_ctl.kind == STAT_RECORD) ? mean_new : mean_run;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_run  <= '0;
      max_run  <= '0;
      run_sum  <= '0;
      runs     <= '0;
      mean_run <= '0;
    end else if (pop && head_ctl.kind == STAT_RECORD) begin
      min_run <= min_run_next;
      max_run <= max_run_next;
      run_sum <= run_sum_next;
      runs    <= runs_next;
    end else if (pop && head_ctl.kind == STAT_CLEAR) begin
      min_run  <= '0;
      max_run  <= '0;
      run_sum  <= '0;
      runs     <= '0;
      mean_run <= '0;
    end else if (load_out && hold_ctl.kind == STAT_RECORD) begin
      mean_run <= mean_new;
    end
  end

  // held transaction and divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      hold_ctl   <= head_ctl;
      hold_count <= head_count;
      dq         <= run_sum_next;
      rem        <= '0;
      div_cnt    <= '0;
    end else if (div_step) begin
      dq      <= {dq[SUM_BITS-2:0], fits};
      rem     <= fits ? trial_diff[RUNS_BITS-1:0] : trial[RUNS_BITS-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      elapsed      <= FIELD_W'(hold_count);
      running      <= hold_ctl.running;
      paused       <= hold_ctl.paused;
      min_time     <= FIELD_W'(min_run);
      max_time     <= FIELD_W'(max_run);
      average_time <= FIELD_W'(mean_show);
      run_count    <= RUN_CNT_W'(runs);
    end
  end

endmodule
